>>> src/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg
// Shared types and constants for the hex text to bytes unit.
// ----------------------------------------------------------------------------
package htb_pkg;

   localparam int CountBits    = 10;
   localparam int CapBits      = 10;
   localparam int ByteCountBits = 10;

   localparam logic [CapBits-1:0] CapacityReset = CapBits'(64);

   // Input item kinds
   localparam logic KindChar = 1'b0;
   localparam logic KindEnd  = 1'b1;

   // Result item kinds
   localparam logic ResultByte   = 1'b0;
   localparam logic ResultStatus = 1'b1;

   // Separator characters
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharUnder = 8'h5F;

   // Digit ranges
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharLowA   = 8'h61;
   localparam logic [7:0] CharLowF   = 8'h66;
   localparam logic [7:0] CharUpA    = 8'h41;
   localparam logic [7:0] CharUpF    = 8'h46;
   localparam logic [7:0] LetterBase = 8'd10;

   typedef struct packed {
      logic       is_sep;
      logic       is_hex;
      logic [3:0] nibble;
   } char_class_type;

   typedef struct packed {
      logic                     result_kind;
      logic [7:0]               data_byte;
      logic                     ok;
      logic [ByteCountBits-1:0] byte_count;
   } rsp_item_type;

endpackage

>>> src/htb_req_if.sv
// ----------------------------------------------------------------------------
// htb_req_if
// Input channel: one character or end-of-text marker per transaction.
// ----------------------------------------------------------------------------
interface htb_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_code;

   modport source (output valid, output kind, output char_code, input ready);
   modport sink   (input valid, input kind, input char_code, output ready);
endinterface

>>> src/htb_rsp_if.sv
// ----------------------------------------------------------------------------
// htb_rsp_if
// Result channel: one decoded byte or final status per transaction.
// ----------------------------------------------------------------------------
interface htb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              result_kind;
   logic [7:0]                        data_byte;
   logic                              ok;
   logic [htb_pkg::ByteCountBits-1:0] byte_count;

   modport source (output valid, output result_kind, output data_byte,
                   output ok, output byte_count, input ready);
   modport sink   (input valid, input result_kind, input data_byte,
                   input ok, input byte_count, output ready);
endinterface

>>> src/hex_text_to_bytes_unit.sv
// ----------------------------------------------------------------------------
// hex_text_to_bytes_unit
// Parses ASCII hex text into bytes and reports a status at end of text.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one character (kind 0) or an end marker (kind 1) per
//   transaction. Separators (space, colon, dash, underscore) are skipped; hex
//   digit pairs, high nibble first, produce one byte transaction on rsp_chan.
//   A bad character or a byte beyond csr capacity sets a sticky error; later
//   characters are then dropped. The end marker always yields one status
//   transaction (ok, byte_count) and clears the text state.
//   One character per cycle is accepted while req_chan.ready is high. A result
//   is valid on rsp_chan the cycle after its character is accepted when the
//   output register is free or read that cycle; the text state is registered.
//   A two-entry output stage (output register plus skid register) keeps
//   req_chan.ready registered; it drops while the skid register is full,
//   from a cycle in which the receiver stalls with a new result arriving
//   until the receiver takes the waiting one.
//   csr_wr_en writes capacity (reset 64); write only while idle.
//   Reset (synchronous, active high) empties the output stage and clears
//   all text state.
// ----------------------------------------------------------------------------
module hex_text_to_bytes_unit (
   input  logic                         clock,
   input  logic                         reset,
   htb_req_if.sink                      req_chan,
   htb_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [htb_pkg::CapBits-1:0]  csr_wr_data
);

   logic [htb_pkg::CapBits-1:0]   capacity_ff;
   logic                          nibble_pending_ff, nibble_pending_in;
   logic [3:0]                    pending_nibble_ff, pending_nibble_in;
   logic [htb_pkg::CountBits-1:0] bytes_done_ff, bytes_done_in;
   logic                          error_seen_ff, error_seen_in;

   logic                          out_valid_ff, out_valid_in;
   htb_pkg::rsp_item_type         out_item_ff, out_item_in;
   logic                          skid_valid_ff, skid_valid_in;
   htb_pkg::rsp_item_type         skid_item_ff, skid_item_in;

   htb_pkg::char_class_type       char_class;
   htb_pkg::rsp_item_type         new_item;
   logic                          accept;
   logic                          produce;
   logic                          pop;
   logic                          full;

   htb_char_decode u_char_decode (
      .char_code  (req_chan.char_code),
      .char_class (char_class)
   );

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = out_valid_ff && rsp_chan.ready;

   assign full = (bytes_done_ff >= htb_pkg::CountBits'(capacity_ff)) ||
                 (bytes_done_ff == {htb_pkg::CountBits{1'b1}});

   // Per-character step
   always_comb begin
      nibble_pending_in = nibble_pending_ff;
      pending_nibble_in = pending_nibble_ff;
      bytes_done_in     = bytes_done_ff;
      error_seen_in     = error_seen_ff;
      produce           = 1'b0;
      new_item          = '0;
      if (accept) begin
         if (req_chan.kind == htb_pkg::KindEnd) begin
            produce              = 1'b1;
            new_item.result_kind = htb_pkg::ResultStatus;
            new_item.ok          = !error_seen_ff && !nibble_pending_ff &&
                                   (bytes_done_ff != '0);
            new_item.byte_count  = htb_pkg::ByteCountBits'(bytes_done_ff);
            nibble_pending_in    = 1'b0;
            pending_nibble_in    = 4'd0;
            bytes_done_in        = '0;
            error_seen_in        = 1'b0;
         end else if (!error_seen_ff && !char_class.is_sep) begin
            if (!char_class.is_hex) begin
               error_seen_in = 1'b1;
            end else if (!nibble_pending_ff) begin
               pending_nibble_in = char_class.nibble;
               nibble_pending_in = 1'b1;
            end else if (full) begin
               error_seen_in = 1'b1;
            end else begin
               produce              = 1'b1;
               new_item.result_kind = htb_pkg::ResultByte;
               new_item.data_byte   = {pending_nibble_ff, char_class.nibble};
               bytes_done_in        = bytes_done_ff + 1'b1;
               nibble_pending_in    = 1'b0;
               pending_nibble_in    = 4'd0;
            end
         end
      end
   end

   // Output register plus skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (produce) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_item_in  = new_item;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = new_item;
         end
      end else if (pop) begin
         // advance skid into the output slot
         out_valid_in  = skid_valid_ff;
         out_item_in   = skid_item_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff       <= htb_pkg::CapacityReset;
         nibble_pending_ff <= 1'b0;
         pending_nibble_ff <= 4'd0;
         bytes_done_ff     <= '0;
         error_seen_ff     <= 1'b0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         nibble_pending_ff <= nibble_pending_in;
         pending_nibble_ff <= pending_nibble_in;
         bytes_done_ff     <= bytes_done_in;
         error_seen_ff     <= error_seen_in;
         out_valid_ff      <= out_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = out_item_ff.result_kind;
   assign rsp_chan.data_byte   = out_item_ff.data_byte;
   assign rsp_chan.ok          = out_item_ff.ok;
   assign rsp_chan.byte_count  = out_item_ff.byte_count;

   // skid never holds a transaction while the output slot is empty
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // end marker clears the text state
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.kind == htb_pkg::KindEnd) |=>
         (!nibble_pending_ff && !error_seen_ff && bytes_done_ff == '0))
      else $error("text state not cleared after end marker");

   // error stays set until an end marker
   assert property (@(posedge clock) disable iff (reset)
      (error_seen_ff && !(accept && req_chan.kind == htb_pkg::KindEnd)) |=>
         error_seen_ff)
      else $error("sticky error dropped");

   // every byte transaction advances the count by one
   assert property (@(posedge clock) disable iff (reset)
      (produce && new_item.result_kind == htb_pkg::ResultByte) |=>
         (bytes_done_ff == $past(bytes_done_ff) + 1'b1))
      else $error("byte count did not advance");

   // hold the skid transaction while the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_chan.ready) |=> skid_valid_ff)
      else $error("skid transaction lost during stall");

endmodule

>>> src/htb_char_decode.sv
// ----------------------------------------------------------------------------
// htb_char_decode
// Classifies one ASCII code as separator or hex digit and gives its nibble.
// ----------------------------------------------------------------------------
module htb_char_decode (
   input  logic [7:0]                    char_code,
   output htb_pkg::char_class_type       char_class
);

   logic [7:0] digit_value;

   always_comb begin
      char_class.is_sep = (char_code == htb_pkg::CharSpace) ||
                          (char_code == htb_pkg::CharColon) ||
                          (char_code == htb_pkg::CharDash)  ||
                          (char_code == htb_pkg::CharUnder);
      char_class.is_hex = 1'b1;
      digit_value       = 8'd0;
      if (char_code inside {[htb_pkg::CharZero:htb_pkg::CharNine]}) begin
         digit_value = char_code - htb_pkg::CharZero;
      end else if (char_code inside {[htb_pkg::CharLowA:htb_pkg::CharLowF]}) begin
         digit_value = char_code - htb_pkg::CharLowA + htb_pkg::LetterBase;
      end else if (char_code inside {[htb_pkg::CharUpA:htb_pkg::CharUpF]}) begin
         digit_value = char_code - htb_pkg::CharUpA + htb_pkg::LetterBase;
      end else begin
         char_class.is_hex = 1'b0;
      end
      char_class.nibble = digit_value[3:0];
   end

endmodule

>>> sim/tb_hex_text_to_bytes_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_text_to_bytes_unit
// Feeds hex text, separators, bad characters and end markers into the parser
// and checks every byte and status transaction against a cycle-free model
// of the text state, under three sender/receiver stall patterns and several
// capacity settings.
// ----------------------------------------------------------------------------
module tb_hex_text_to_bytes_unit;

   localparam int PhaseItems  = 207;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 4;

   // Tracks the text state and holds the transactions the unit still owes.
   class byte_stream_scoreboard;
      logic [htb_pkg::CapBits-1:0]   capacity;
      logic                          nibble_pending;
      logic [3:0]                    pending_nibble;
      logic [htb_pkg::CountBits-1:0] bytes_done;
      logic                          error_seen;
      htb_pkg::rsp_item_type         owed_results[$];
      int                            mismatches;
      int                            unexpected;
      int                            checked;

      function new();
         capacity   = htb_pkg::CapacityReset;
         mismatches = 0;
         unexpected = 0;
         checked    = 0;
         clear_text();
      endfunction

      function void clear_text();
         nibble_pending = 1'b0;
         pending_nibble = 4'd0;
         bytes_done     = '0;
         error_seen     = 1'b0;
      endfunction

      // Returns 1 when the transaction changed state or owes a result.
      function bit note_char(input logic kind, input logic [7:0] ch);
         htb_pkg::rsp_item_type item;
         logic [3:0]            digit;
         item = '0;
         if (kind == htb_pkg::KindEnd) begin
            item.result_kind = htb_pkg::ResultStatus;
            item.ok          = !error_seen && !nibble_pending && (bytes_done != 0);
            item.byte_count  = htb_pkg::ByteCountBits'(bytes_done);
            owed_results.push_back(item);
            clear_text();
            return 1'b1;
         end
         if (error_seen) return 1'b0;
         if (ch == htb_pkg::CharSpace || ch == htb_pkg::CharColon ||
             ch == htb_pkg::CharDash || ch == htb_pkg::CharUnder)
            return 1'b0;
         if (ch >= htb_pkg::CharZero && ch <= htb_pkg::CharNine) begin
            digit = 4'(ch - htb_pkg::CharZero);
         end else if (ch >= htb_pkg::CharLowA && ch <= htb_pkg::CharLowF) begin
            digit = 4'(ch - htb_pkg::CharLowA + htb_pkg::LetterBase);
         end else if (ch >= htb_pkg::CharUpA && ch <= htb_pkg::CharUpF) begin
            digit = 4'(ch - htb_pkg::CharUpA + htb_pkg::LetterBase);
         end else begin
            error_seen = 1'b1;
            return 1'b1;
         end
         if (!nibble_pending) begin
            pending_nibble = digit;
            nibble_pending = 1'b1;
            return 1'b1;
         end
         // Overflow: drop the pair and go sticky
         if (bytes_done >= capacity || bytes_done == {htb_pkg::CountBits{1'b1}}) begin
            error_seen = 1'b1;
            return 1'b1;
         end
         item.result_kind = htb_pkg::ResultByte;
         item.data_byte   = {pending_nibble, digit};
         owed_results.push_back(item);
         bytes_done     = bytes_done + 1'b1;
         nibble_pending = 1'b0;
         pending_nibble = 4'd0;
         return 1'b1;
      endfunction

      function void check_result(input htb_pkg::rsp_item_type got);
         htb_pkg::rsp_item_type want;
         checked++;
         if (owed_results.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("[%0t] unexpected result: kind=%0d byte=%02h ok=%0d count=%0d",
                        $realtime, got.result_kind, got.data_byte, got.ok, got.byte_count);
            return;
         end
         want = owed_results.pop_front();
         if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
             got.ok !== want.ok || got.byte_count !== want.byte_count) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
               $write("[%0t] mismatch: expected kind=%0d byte=%02h ok=%0d count=%0d, ",
                      $realtime, want.result_kind, want.data_byte, want.ok,
                      want.byte_count);
               $display("got kind=%0d byte=%02h ok=%0d count=%0d",
                        got.result_kind, got.data_byte, got.ok, got.byte_count);
            end
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_wr_en;
   logic [htb_pkg::CapBits-1:0] csr_wr_data;

   htb_req_if req_chan ();
   htb_rsp_if rsp_chan ();

   hex_text_to_bytes_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   byte_stream_scoreboard stream_sb = new();

   int src_idle_pct  = 0;
   int sink_idle_pct = 0;
   int accepted_items = 0;
   int effective_items = 0;
   int texts_sent = 0;
   int capacity_writes = 0;
   int stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: check each result transaction, then pick the next ready.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         stream_sb.check_result({rsp_chan.result_kind, rsp_chan.data_byte,
                                 rsp_chan.ok, rsp_chan.byte_count});
      rsp_chan.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("watchdog: no transaction for %0d cycles", StallLimit);
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] ch);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.char_code <= ch;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      accepted_items++;
      if (stream_sb.note_char(kind, ch)) effective_items++;
   endtask

   task automatic send_end();
      send_item(htb_pkg::KindEnd, 8'($urandom_range(0, 255)));
      texts_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_item(htb_pkg::KindChar, s[i]);
   endtask

   // Hold valid low until every owed result has arrived, then let the pipe settle.
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (stream_sb.owed_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [htb_pkg::CapBits-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      stream_sb.capacity = value;
      csr_wr_en <= 1'b0;
      capacity_writes++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return htb_pkg::CharZero + 8'(nib);
      return (upper ? htb_pkg::CharUpA : htb_pkg::CharLowA) + 8'(nib) -
             htb_pkg::LetterBase;
   endfunction

   function automatic logic [7:0] separator_char();
      case ($urandom_range(0, 3))
         0: return htb_pkg::CharSpace;
         1: return htb_pkg::CharColon;
         2: return htb_pkg::CharDash;
         default: return htb_pkg::CharUnder;
      endcase
   endfunction

   function automatic logic [htb_pkg::CapBits-1:0] pick_capacity();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return htb_pkg::CapBits'(1);
         2: return {htb_pkg::CapBits{1'b1}};
         3: return htb_pkg::CapBits'($urandom_range(0, 1023));
         default: return htb_pkg::CapBits'($urandom_range(2, 12));
      endcase
   endfunction

   // One text: mostly clean hex with separators; some with a random inserted
   // character, an odd trailing digit, or pure noise.
   task automatic send_random_text();
      int nbytes;
      int mode;
      int noise_pos;
      int len;
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
      mode   = $urandom_range(0, 9);
      if (mode == 0) begin
         len = $urandom_range(1, 10);
         for (int k = 0; k < len; k++)
            send_item(($urandom_range(0, 7) == 0) ? htb_pkg::KindEnd : htb_pkg::KindChar,
                      8'($urandom_range(0, 255)));
         send_end();
         return;
      end
      noise_pos = (mode == 1) ? $urandom_range(0, 2 * nbytes) : -1;
      for (int k = 0; k <= 2 * nbytes; k++) begin
         if (k == noise_pos) send_item(htb_pkg::KindChar, 8'($urandom_range(0, 255)));
         if (k < 2 * nbytes && !(mode == 2 && k == 2 * nbytes - 1)) begin
            if ($urandom_range(0, 3) == 0) send_item(htb_pkg::KindChar, separator_char());
            send_item(htb_pkg::KindChar,
                      hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
         end
      end
      send_end();
   endtask

   initial begin
      int phase_start;
      int leftover;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = htb_pkg::KindChar;
      req_chan.char_code = 8'd0;
      rsp_chan.ready     = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset capacity, separators, both cases, odd digit, bad codes
      src_idle_pct  = 16;
      sink_idle_pct = 56;
      send_end();
      send_string("00 FF:af-A9_");
      send_end();
      send_string("7");
      send_end();
      send_string("5Ag1");
      send_end();
      send_item(htb_pkg::KindChar, 8'h00);
      send_end();
      send_item(htb_pkg::KindChar, 8'hFF);
      send_end();
      // Zero capacity, then a capacity of one byte
      wait_until_drained();
      write_capacity('0);
      send_string("12");
      send_end();
      wait_until_drained();
      write_capacity(htb_pkg::CapBits'(1));
      send_string("1234");
      send_end();

      for (int phase = 0; phase < 3; phase++) begin
         wait_until_drained();
         case (phase)
            0: begin src_idle_pct = 16; sink_idle_pct = 56; end
            1: begin src_idle_pct = 56; sink_idle_pct = 16; end
            default: begin src_idle_pct = 0; sink_idle_pct = 0; end
         endcase
         write_capacity(phase == 1 ? {htb_pkg::CapBits{1'b1}} : pick_capacity());
         phase_start = accepted_items;
         for (int t = 1; accepted_items - phase_start < PhaseItems; t++) begin
            if (t % 5 == 0) begin
               wait_until_drained();
               write_capacity(pick_capacity());
            end
            send_random_text();
         end
      end

      wait_until_drained();
      leftover = stream_sb.owed_results.size();
      if (leftover != 0) $display("%0d expected results never arrived", leftover);
      $display("Run covered %0d input transactions (%0d texts, %0d not ignored) and",
               accepted_items, texts_sent, effective_items);
      $display("%0d result transactions, with %0d capacity writes over three stall patterns.",
               stream_sb.checked, capacity_writes);
      if (stream_sb.mismatches + stream_sb.unexpected + leftover == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
src/htb_pkg.sv
src/htb_req_if.sv
src/htb_rsp_if.sv
src/htb_char_decode.sv
src/hex_text_to_bytes_unit.sv
sim/tb_hex_text_to_bytes_unit.sv
